>>> sv/dlrt_pkg.sv
// dlrt_pkg: shared types and constants of the delta-list retransmit timer queue
// operation, result kind and sequencer state encodings, slot sizing, reset values
// no dependencies
package dlrt_pkg;

  localparam int SLOT_COUNT     = 8;
  localparam int SLOT_AW        = 3;
  localparam int CNT_W          = 4;
  localparam int ENTRY_ID_W     = 3;
  localparam int TIMEOUT_W      = 8;
  localparam int ID_BITS_DEF    = 3;
  localparam int DELTA_BITS_DEF = 8;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 8'd5;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_CANCEL = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_EXPIRED = 2'd1,
    KIND_MISS    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_SUM,
    ST_TICK,
    ST_CHECK,
    ST_FINISH
  } state_t;

endpackage

>>> sv/delta_list_retransmit_timers.sv
// delta_list_retransmit_timers: up to eight retransmit timers kept as a delta list
// holds the slot register file, the sequencer and its shared adder
// depends on dlrt_pkg
//
// Input channel in_*: in_tuser carries the operation (tick, start, cancel), in_tdata
// the timer id. Every input gives one or more results on out_*; out_tlast marks the
// final result of an input. Expired timers come out one transfer each, in order.
// cfg_*: writes the timeout in ticks; it is always ready and should be written only
// while the block is idle.
// An input is held by a small sequencer that steps one slot per cycle through a
// single slot read port and one shared adder. Its steps for each input:
//   start:  search, remove an old entry, sum the deltas, append
//   cancel: search, then shift the tail down
//   tick:   finish at once on an empty queue, else decrement the head delta,
//           then remove each expired timer from the head
// in_tready is high only between inputs.
// Results leave through an output register, so the next input is taken while the
// last result still waits; a stalled receiver holds the sequencer only when it has
// another result to hand over.
// Reset empties the queue and sets the timeout to five ticks; slot contents are
// not cleared, since only slots below the occupancy are read.
module delta_list_retransmit_timers
  import dlrt_pkg::*;
#(
  parameter int ID_BITS    = ID_BITS_DEF,
  parameter int DELTA_BITS = DELTA_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [2:0] entry_id, [7:3] zero
  input  logic [1:0] in_tuser,   // [1:0] opcode
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [2:0] expired_id, [6:3] live_count, [7] zero
  output logic [1:0] out_tuser,  // [1:0] kind
  output logic       out_tlast,  // last
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data    // [7:0] timeout_ticks
);

  localparam int SUM_W = (DELTA_BITS + 3 > TIMEOUT_W) ? DELTA_BITS + 3 : TIMEOUT_W;
  localparam logic [DELTA_BITS-1:0] DELTA_MAX = {DELTA_BITS{1'b1}};
  localparam logic [ENTRY_ID_W-1:0] IN_ID_MASK =
    (ID_BITS >= ENTRY_ID_W) ? {ENTRY_ID_W{1'b1}} : ENTRY_ID_W'((1 << ID_BITS) - 1);

  // slot register file: one read port, one write port
  logic [ID_BITS-1:0]    slot_ids_r    [SLOT_COUNT];
  logic [DELTA_BITS-1:0] slot_deltas_r [SLOT_COUNT];

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      occ_r, occ_nxt;
  logic                  first_r, first_nxt;
  logic [DELTA_BITS-1:0] held_r, held_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  op_t                   op_r, op_nxt;
  logic [ID_BITS-1:0]    id_r, id_nxt;
  kind_t                 res_kind_r, res_kind_nxt;
  logic [ID_BITS-1:0]    res_id_r, res_id_nxt;
  logic                  pend_r, pend_nxt;
  logic [TIMEOUT_W-1:0]  timeout_r;

  logic                  out_valid_r;
  kind_t                 out_kind_r;
  logic [ENTRY_ID_W-1:0] out_id_r;
  logic [CNT_W-1:0]      out_cnt_r;
  logic                  out_last_r;

  logic                  out_load;
  kind_t                 out_kind_nxt;
  logic [ENTRY_ID_W-1:0] out_id_nxt;
  logic                  out_last_nxt;
  logic                  out_free;

  logic [SLOT_AW-1:0]    rd_addr;
  logic [ID_BITS-1:0]    rd_id;
  logic [DELTA_BITS-1:0] rd_delta;
  logic                  wr_en;
  logic [SLOT_AW-1:0]    wr_addr;
  logic [ID_BITS-1:0]    wr_id;
  logic [DELTA_BITS-1:0] wr_delta;

  logic [SUM_W-1:0]      add_a, add_b, add_y;
  logic [DELTA_BITS-1:0] fold_sat;
  logic [SUM_W-1:0]      remain;
  logic [DELTA_BITS-1:0] new_delta;
  logic [ID_BITS-1:0]    in_id;
  logic [CNT_W-1:0]      idx_inc;

  assign in_id    = ID_BITS'(in_tdata[ENTRY_ID_W-1:0] & IN_ID_MASK);
  assign out_free = !out_valid_r || out_tready;
  assign idx_inc  = idx_r + CNT_W'(1);

  // shift steps read the slot above the one being written
  assign rd_addr  = (state_r == ST_SHIFT) ? idx_inc[SLOT_AW-1:0] : idx_r[SLOT_AW-1:0];
  assign rd_id    = slot_ids_r[rd_addr];
  assign rd_delta = slot_deltas_r[rd_addr];

  // shared adder: running delta sum, or fold of a removed delta into its successor
  assign add_a    = (state_r == ST_SUM) ? sum_r : SUM_W'(held_r);
  assign add_b    = SUM_W'(rd_delta);
  assign add_y    = add_a + add_b;
  assign fold_sat = (add_y > SUM_W'(DELTA_MAX)) ? DELTA_MAX : add_y[DELTA_BITS-1:0];

  assign remain    = (SUM_W'(timeout_r) > sum_r) ? SUM_W'(timeout_r) - sum_r : '0;
  assign new_delta = (remain > SUM_W'(DELTA_MAX)) ? DELTA_MAX : remain[DELTA_BITS-1:0];

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    occ_nxt      = occ_r;
    first_nxt    = first_r;
    held_nxt     = held_r;
    sum_nxt      = sum_r;
    op_nxt       = op_r;
    id_nxt       = id_r;
    res_kind_nxt = res_kind_r;
    res_id_nxt   = res_id_r;
    pend_nxt     = pend_r;
    out_load     = 1'b0;
    out_kind_nxt = KIND_ACK;
    out_id_nxt   = '0;
    out_last_nxt = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = idx_r[SLOT_AW-1:0];
    wr_id        = rd_id;
    wr_delta     = rd_delta;
    in_tready    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          id_nxt       = in_id;
          idx_nxt      = '0;
          pend_nxt     = 1'b0;
          res_kind_nxt = KIND_ACK;
          res_id_nxt   = '0;
          unique case (op_t'(in_tuser))
            OP_TICK: begin
              op_nxt    = OP_TICK;
              state_nxt = (occ_r == '0) ? ST_FINISH : ST_TICK;
            end
            OP_START: begin
              op_nxt    = OP_START;
              state_nxt = ST_SEARCH;
            end
            OP_CANCEL: begin
              op_nxt    = OP_CANCEL;
              state_nxt = ST_SEARCH;
            end
            default: begin
              op_nxt    = OP_TICK;
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end

      ST_SEARCH: begin
        if (idx_r == occ_r) begin
          if (op_r == OP_CANCEL) begin
            res_kind_nxt = KIND_MISS;
            state_nxt    = ST_FINISH;
          end else begin
            idx_nxt   = '0;
            sum_nxt   = '0;
            state_nxt = ST_SUM;
          end
        end else if (rd_id == id_r) begin
          held_nxt  = rd_delta;
          first_nxt = 1'b1;
          state_nxt = ST_SHIFT;
        end else begin
          idx_nxt = idx_inc;
        end
      end

      // remove slot idx: move every later slot down by one, one per cycle
      ST_SHIFT: begin
        if (idx_inc < occ_r) begin
          wr_en     = 1'b1;
          wr_delta  = first_r ? fold_sat : rd_delta;
          first_nxt = 1'b0;
          idx_nxt   = idx_inc;
        end else begin
          occ_nxt = occ_r - CNT_W'(1);
          idx_nxt = '0;
          sum_nxt = '0;
          unique case (op_r)
            OP_TICK:   state_nxt = ST_CHECK;
            OP_START:  state_nxt = ST_SUM;
            default:   state_nxt = ST_FINISH;
          endcase
        end
      end

      ST_SUM: begin
        if (idx_r == occ_r) begin
          if (occ_r < CNT_W'(SLOT_COUNT)) begin
            wr_en    = 1'b1;
            wr_addr  = occ_r[SLOT_AW-1:0];
            wr_id    = id_r;
            wr_delta = new_delta;
            occ_nxt  = occ_r + CNT_W'(1);
          end
          state_nxt = ST_FINISH;
        end else begin
          sum_nxt = add_y;
          idx_nxt = idx_inc;
        end
      end

      ST_TICK: begin
        if (rd_delta != '0) begin
          wr_en    = 1'b1;
          wr_delta = rd_delta - DELTA_BITS'(1);
        end
        state_nxt = ST_CHECK;
      end

      // an expiry is held back until it is known whether another one follows
      ST_CHECK: begin
        if (occ_r != '0 && rd_delta == '0) begin
          if (!pend_r || out_free) begin
            if (pend_r) begin
              out_load     = 1'b1;
              out_kind_nxt = KIND_EXPIRED;
              out_id_nxt   = ENTRY_ID_W'(res_id_r);
            end
            pend_nxt     = 1'b1;
            res_kind_nxt = KIND_EXPIRED;
            res_id_nxt   = rd_id;
            held_nxt     = '0;
            first_nxt    = 1'b1;
            state_nxt    = ST_SHIFT;
          end
        end else begin
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_kind_nxt = res_kind_r;
          out_id_nxt   = (res_kind_r == KIND_EXPIRED) ? ENTRY_ID_W'(res_id_r) : '0;
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      timeout_r   <= TIMEOUT_RST;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      pend_r  <= pend_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        timeout_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    first_r    <= first_nxt;
    held_r     <= held_nxt;
    sum_r      <= sum_nxt;
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    res_kind_r <= res_kind_nxt;
    res_id_r   <= res_id_nxt;
    if (out_load) begin
      out_kind_r <= out_kind_nxt;
      out_id_r   <= out_id_nxt;
      out_cnt_r  <= occ_nxt;
      out_last_r <= out_last_nxt;
    end
    if (wr_en) begin
      slot_ids_r[wr_addr]    <= wr_id;
      slot_deltas_r[wr_addr] <= wr_delta;
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {1'b0, out_cnt_r, out_id_r};
  assign out_tlast  = out_last_r;

  // a result that is not the last of its input is always an expiry
  a_not_last_is_expiry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser == KIND_EXPIRED)
    else $error("non-final result that is not an expiry");

  a_id_zero_unless_expiry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_EXPIRED |-> out_tdata[2:0] == '0)
    else $error("expired_id set on a result that is not an expiry");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(SLOT_COUNT))
    else $error("occupancy above slot count");

  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> occ_r == $past(occ_r) || occ_r == $past(occ_r) + CNT_W'(1)
      || occ_r == $past(occ_r) - CNT_W'(1))
    else $error("occupancy moved by more than one slot");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while the previous one is in work");

endmodule
